// File: rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, constants and helper functions of the Playfair encryptor:
// command codes, letter codes, controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int SqDim     = 5;
    localparam int SqSize    = SqDim * SqDim;
    localparam int NumLetter = 26;
    localparam int CodeW     = 5;
    localparam int PosW      = $clog2(SqSize);
    localparam int RcW       = $clog2(SqDim);

    localparam logic [CodeW-1:0] CodeI = 5'd8;
    localparam logic [CodeW-1:0] CodeJ = 5'd9;
    localparam logic [CodeW-1:0] CodeX = 5'd23;
    localparam logic [CodeW-1:0] CodeLast = 5'(NumLetter - 1);
    localparam logic [PosW-1:0]  SqFull = PosW'(SqSize);

    localparam logic [7:0] AsciiUpA = 8'h41;
    localparam logic [7:0] AsciiUpZ = 8'h5A;
    localparam logic [7:0] AsciiLoA = 8'h61;
    localparam logic [7:0] AsciiLoZ = 8'h7A;
    localparam logic [7:0] AsciiCaseOfs = 8'h20;

    typedef enum logic [1:0] {
        CMD_KEY_START = 2'd0,
        CMD_KEY_BYTE  = 2'd1,
        CMD_PLAIN     = 2'd2,
        CMD_END       = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [RcW-1:0] row;
        logic [RcW-1:0] col;
    } rc_t;

    typedef struct packed {
        logic             valid;
        logic [CodeW-1:0] code;
    } letter_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear_key;
        logic place_key;
        logic fill_step;
        logic pair_step;
        logic look_a;
        logic look_b;
        logic calc;
        logic rd1;
        logic rd2;
        logic emit1;
        logic emit2;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic complete;
        logic pending;
        logic go_digraph;
        logic fill_last;
        logic out_free;
    } dp_status_t;

    // upper-case, fold j into i, flag non-letters
    function automatic letter_t clean_byte(input logic [7:0] ch);
        logic [7:0] up;
        letter_t    res;
        up = ch;
        if (ch >= AsciiLoA && ch <= AsciiLoZ)
        begin
            up = ch - AsciiCaseOfs;
        end
        res.valid = (up >= AsciiUpA) && (up <= AsciiUpZ);
        res.code  = CodeW'(up - AsciiUpA);
        if (res.code == CodeJ)
        begin
            res.code = CodeI;
        end
        return res;
    endfunction

    function automatic rc_t pos_to_rc(input logic [PosW-1:0] pos);
        rc_t res;
        if (pos >= PosW'(4 * SqDim))
            res.row = RcW'(4);
        else if (pos >= PosW'(3 * SqDim))
            res.row = RcW'(3);
        else if (pos >= PosW'(2 * SqDim))
            res.row = RcW'(2);
        else if (pos >= PosW'(SqDim))
            res.row = RcW'(1);
        else
            res.row = RcW'(0);
        res.col = RcW'(pos - PosW'(res.row) * PosW'(SqDim));
        return res;
    endfunction

    function automatic logic [PosW-1:0] rc_to_pos(input rc_t rc);
        return PosW'(rc.row) * PosW'(SqDim) + PosW'(rc.col);
    endfunction

    function automatic logic [RcW-1:0] inc_mod(input logic [RcW-1:0] v);
        return (v == RcW'(SqDim - 1)) ? RcW'(0) : v + RcW'(1);
    endfunction

endpackage

// File: rtl/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfe_ram #(
    parameter int Width = 5,
    parameter int Depth = 25
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pfe_ctrl.sv
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer of the Playfair encryptor: steps one item through decode,
// square fill, pairing, lookups and the two output transfers.
// ----------------------------------------------------------------------------
module pfe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pfe_pkg::dp_status_t   status,
    output pfe_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_DECIDE = 11'b000_0000_0010,
        ST_FILL   = 11'b000_0000_0100,
        ST_PAIR   = 11'b000_0000_1000,
        ST_LOOK_A = 11'b000_0001_0000,
        ST_LOOK_B = 11'b000_0010_0000,
        ST_CALC   = 11'b000_0100_0000,
        ST_RD1    = 11'b000_1000_0000,
        ST_RD2    = 11'b001_0000_0000,
        ST_EMIT1  = 11'b010_0000_0000,
        ST_EMIT2  = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.clear_key = (status.cmd == pfe_pkg::CMD_KEY_START);
                cmd.place_key = (status.cmd == pfe_pkg::CMD_KEY_BYTE);
                if (status.cmd == pfe_pkg::CMD_KEY_START || status.cmd == pfe_pkg::CMD_KEY_BYTE)
                    state_next = ST_IDLE;
                else if (status.cmd == pfe_pkg::CMD_END && !status.pending)
                    state_next = ST_IDLE;
                else if (!status.complete)
                    state_next = ST_FILL;
                else
                    state_next = ST_PAIR;
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_last)
                begin
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                cmd.pair_step = 1'b1;
                state_next    = status.go_digraph ? ST_LOOK_A : ST_IDLE;
            end
            ST_LOOK_A:
            begin
                cmd.look_a = 1'b1;
                state_next = ST_LOOK_B;
            end
            ST_LOOK_B:
            begin
                cmd.look_b = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.rd1    = 1'b1;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = ST_EMIT1;
            end
            ST_EMIT1:
            begin
                cmd.emit1 = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_EMIT2;
                end
            end
            ST_EMIT2:
            begin
                cmd.emit2 = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/pfe_datapath.sv
// ----------------------------------------------------------------------------
// pfe_datapath
// Key square and letter-position memories, used-letter map, pending letter,
// digraph rule logic and the output register.
// ----------------------------------------------------------------------------
module pfe_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfe_pkg::ctrl_cmd_t   cmd,
    output pfe_pkg::dp_status_t  status,
    input  logic [1:0]           in_cmd,
    input  logic [7:0]           in_char,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [6:0]           out_letter,
    output logic                 out_pair_end,
    output logic                 out_last
);

    localparam int CodeW = pfe_pkg::CodeW;
    localparam int PosW  = pfe_pkg::PosW;

    pfe_pkg::cmd_t           cmd_reg;
    logic [CodeW-1:0]        code_reg;
    logic                    code_ok_reg;
    logic [pfe_pkg::NumLetter-1:0] used_reg;
    logic [PosW-1:0]         fill_reg;
    logic                    complete_reg;
    logic                    pending_reg;
    logic [CodeW-1:0]        pend_letter_reg;
    logic [CodeW-1:0]        walk_reg;
    logic [CodeW-1:0]        a_reg;
    logic [CodeW-1:0]        b_reg;
    logic [PosW-1:0]         pa_reg;
    logic [PosW-1:0]         o1_reg;
    logic [PosW-1:0]         o2_reg;
    logic [CodeW-1:0]        l1_reg;
    logic                    out_valid_reg;
    logic [6:0]              out_letter_reg;
    logic                    out_pair_end_reg;

    pfe_pkg::letter_t        clean;
    logic [CodeW-1:0]        place_code;
    logic                    place_now;
    logic                    room;
    logic [PosW-1:0]         pos_rdata;
    logic [CodeW-1:0]        sq_rdata;
    pfe_pkg::rc_t            rc1;
    pfe_pkg::rc_t            rc2;
    pfe_pkg::rc_t            orc1;
    pfe_pkg::rc_t            orc2;
    logic                    out_free;

    assign clean      = pfe_pkg::clean_byte(in_char);
    assign room       = fill_reg < pfe_pkg::SqFull;
    assign place_code = cmd.fill_step ? walk_reg : code_reg;
    assign place_now  = room && !used_reg[place_code]
                        && ((cmd.place_key && !complete_reg && code_ok_reg) || cmd.fill_step);
    assign out_free   = !out_valid_reg || out_ready;

    pfe_ram #(
        .Width (CodeW),
        .Depth (pfe_pkg::SqSize)
    ) u_square_ram (
        .clk   (clk),
        .we    (place_now),
        .waddr (fill_reg),
        .wdata (place_code),
        .re    (cmd.rd1 || cmd.rd2),
        .raddr (cmd.rd1 ? o1_reg : o2_reg),
        .rdata (sq_rdata)
    );

    pfe_ram #(
        .Width (PosW),
        .Depth (pfe_pkg::NumLetter)
    ) u_pos_ram (
        .clk   (clk),
        .we    (place_now),
        .waddr (place_code),
        .wdata (fill_reg),
        .re    (cmd.look_a || cmd.look_b),
        .raddr (cmd.look_a ? a_reg : b_reg),
        .rdata (pos_rdata)
    );

    // digraph rules
    always_comb
    begin
        rc1  = pfe_pkg::pos_to_rc(pa_reg);
        rc2  = pfe_pkg::pos_to_rc(pos_rdata);
        orc1 = rc1;
        orc2 = rc2;
        if (rc1.row == rc2.row)
        begin
            orc1.col = pfe_pkg::inc_mod(rc1.col);
            orc2.col = pfe_pkg::inc_mod(rc2.col);
        end
        else if (rc1.col == rc2.col)
        begin
            orc1.row = pfe_pkg::inc_mod(rc1.row);
            orc2.row = pfe_pkg::inc_mod(rc2.row);
        end
        else
        begin
            orc1.col = rc2.col;
            orc2.col = rc1.col;
        end
    end

    // key state and pairing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg        <= pfe_pkg::NumLetter'(1) << pfe_pkg::CodeJ;
            fill_reg        <= '0;
            complete_reg    <= 1'b0;
            pending_reg     <= 1'b0;
            pend_letter_reg <= '0;
            walk_reg        <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                walk_reg <= '0;
            end
            if (cmd.clear_key)
            begin
                used_reg        <= pfe_pkg::NumLetter'(1) << pfe_pkg::CodeJ;
                fill_reg        <= '0;
                complete_reg    <= 1'b0;
                pending_reg     <= 1'b0;
                pend_letter_reg <= '0;
            end
            if (place_now)
            begin
                used_reg[place_code] <= 1'b1;
                fill_reg             <= fill_reg + PosW'(1);
            end
            if (cmd.fill_step)
            begin
                walk_reg <= walk_reg + CodeW'(1);
                if (walk_reg == pfe_pkg::CodeLast)
                begin
                    complete_reg <= 1'b1;
                end
            end
            if (cmd.pair_step)
            begin
                if (cmd_reg == pfe_pkg::CMD_PLAIN && code_ok_reg)
                begin
                    if (!pending_reg)
                    begin
                        pending_reg     <= 1'b1;
                        pend_letter_reg <= code_reg;
                    end
                    else if (pend_letter_reg != code_reg)
                    begin
                        pending_reg     <= 1'b0;
                        pend_letter_reg <= '0;
                    end
                end
                else if (cmd_reg == pfe_pkg::CMD_END)
                begin
                    pending_reg     <= 1'b0;
                    pend_letter_reg <= '0;
                end
            end
        end
    end

    // item fields, lookup pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg     <= pfe_pkg::cmd_t'(in_cmd);
            code_reg    <= clean.code;
            code_ok_reg <= clean.valid;
        end
        if (cmd.pair_step)
        begin
            a_reg <= pend_letter_reg;
            if (cmd_reg == pfe_pkg::CMD_END || pend_letter_reg == code_reg)
                b_reg <= pfe_pkg::CodeX;
            else
                b_reg <= code_reg;
        end
        if (cmd.look_b)
        begin
            pa_reg <= pos_rdata;
        end
        if (cmd.calc)
        begin
            o1_reg <= pfe_pkg::rc_to_pos(orc1);
            o2_reg <= pfe_pkg::rc_to_pos(orc2);
        end
        if (cmd.rd2)
        begin
            l1_reg <= sq_rdata;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit1 || cmd.emit2)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit1)
        begin
            out_letter_reg   <= 7'(l1_reg) + pfe_pkg::AsciiUpA[6:0];
            out_pair_end_reg <= 1'b0;
        end
        else if (cmd.emit2)
        begin
            out_letter_reg   <= 7'(sq_rdata) + pfe_pkg::AsciiUpA[6:0];
            out_pair_end_reg <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_letter   = out_letter_reg;
    assign out_pair_end = out_pair_end_reg;
    assign out_last     = out_pair_end_reg;

    assign status.cmd        = cmd_reg;
    assign status.complete   = complete_reg;
    assign status.pending    = pending_reg;
    assign status.go_digraph = pending_reg
                               && ((cmd_reg == pfe_pkg::CMD_PLAIN && code_ok_reg)
                                   || cmd_reg == pfe_pkg::CMD_END);
    assign status.fill_last  = (walk_reg == pfe_pkg::CodeLast);
    assign status.out_free   = out_free;

endmodule

// File: rtl/playfair_digraph_encryptor.sv
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor
// Streaming Playfair cipher: builds a 5x5 key square from key bytes and
// enciphers plaintext digraphs into two upper-case cipher letters.
// ----------------------------------------------------------------------------
// channel   dir   tdata            tuser        tlast
// s_*       in    char_in[7:0]     cmd[1:0]     -
// m_*       out   cipher_letter    pair_end     last
//
// one item at a time; s_tready is high only while idle
// start key, key byte: decode only; lone plaintext letter: decode and pairing
// digraph: pairing, two position lookups, rule calc, two square reads, plus any m_tready wait
// first plaintext byte after a key first walks all letters to fill the square
// rst_n clears the key state to empty, only j marked used, nothing pending
// ----------------------------------------------------------------------------
module playfair_digraph_encryptor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_in[7:0]
    input  logic [1:0] s_tuser,   // cmd[1:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // cipher_letter[6:0], zero pad[7]
    output logic       m_tuser,   // pair_end
    output logic       m_tlast
);

    pfe_pkg::ctrl_cmd_t  ctrl_cmd;
    pfe_pkg::dp_status_t dp_status;
    logic [6:0]          letter;

    pfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    pfe_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctrl_cmd),
        .status       (dp_status),
        .in_cmd       (s_tuser),
        .in_char      (s_tdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_letter   (letter),
        .out_pair_end (m_tuser),
        .out_last     (m_tlast)
    );

    assign m_tdata = {1'b0, letter};

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    a_last_on_pair_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == m_tuser))
        else $error("last does not mark second letter");

    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >= 8'h41 && m_tdata <= 8'h5A))
        else $error("cipher letter out of range");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tuser |=> m_tvalid || !s_tready)
        else $error("digraph split by idle");

endmodule

// File: tb/playfair_digraph_encryptor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor_tb
// Self-checking bench for the streaming Playfair encryptor. A directed table
// covers case folding, the j to i merge, ignored bytes, doubled letters,
// padding and key rebuild. Random keyed messages and noise follow. Every
// cipher letter is checked against the table or an in-bench model of the key
// square, under phases of source idling, sink stalling and one long sink hold.
// ----------------------------------------------------------------------------
module playfair_digraph_encryptor_tb;

    localparam int TargetItems = 1900;
    localparam int HoldCycles  = 400;
    localparam int SqDim       = pfe_pkg::SqDim;
    localparam int SqSize      = pfe_pkg::SqSize;
    localparam int NumLetter   = pfe_pkg::NumLetter;

    typedef struct {
        logic [6:0] letter;
        logic       pair_end;
        logic       last;
    } cipher_t;

    typedef struct {
        pfe_pkg::cmd_t cmd;
        logic [7:0]    ch;
        bit            fixed;
        int            n;
        logic [7:0]    e1;
        logic [7:0]    e2;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // bench copy of the cipher state
    logic [4:0]  sq [SqSize];
    logic [25:0] used_map;
    int          sq_fill;
    bit          sq_done;
    bit          pend_v;
    logic [4:0]  pend_code;

    cipher_t cipher_q[$];
    row_t    rows[$];

    int src_idle;
    int snk_stall;
    bit hold_req;
    bit hold_done;
    int hold_left;
    int errors;
    int items_sent;
    int letters_checked;
    int keys_started;

    playfair_digraph_encryptor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // char_in[7:0]
        .s_tuser  (s_tuser),   // cmd[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // cipher_letter[6:0], zero pad[7]
        .m_tuser  (m_tuser),   // pair_end
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("playfair_digraph_encryptor: mismatch");
        $finish;
    end

    task automatic place_code(input logic [4:0] code);
        if (!used_map[code] && sq_fill < SqSize)
        begin
            sq[sq_fill] = code;
            sq_fill++;
            used_map[code] = 1'b1;
        end
    endtask

    task automatic fill_square();
        if (!sq_done)
        begin
            for (int n = 0; n < NumLetter; n++)
            begin
                place_code(5'(n));
            end
            sq_done = 1'b1;
        end
    endtask

    function automatic int find_pos(input logic [4:0] code);
        for (int k = 0; k < SqSize; k++)
        begin
            if (sq[k] == code)
            begin
                return k;
            end
        end
        return 0;
    endfunction

    task automatic cipher_pair(input logic [4:0] a, input logic [4:0] b,
                               output logic [6:0] l1, output logic [6:0] l2);
        int pa;
        int pb;
        int o1;
        int o2;
        pa = find_pos(a);
        pb = find_pos(b);
        if (pa / SqDim == pb / SqDim)
        begin
            o1 = (pa / SqDim) * SqDim + (pa % SqDim + 1) % SqDim;
            o2 = (pb / SqDim) * SqDim + (pb % SqDim + 1) % SqDim;
        end
        else if (pa % SqDim == pb % SqDim)
        begin
            o1 = ((pa / SqDim + 1) % SqDim) * SqDim + pa % SqDim;
            o2 = ((pb / SqDim + 1) % SqDim) * SqDim + pb % SqDim;
        end
        else
        begin
            o1 = (pa / SqDim) * SqDim + pb % SqDim;
            o2 = (pb / SqDim) * SqDim + pa % SqDim;
        end
        l1 = 7'(sq[o1]) + 7'h41;
        l2 = 7'(sq[o2]) + 7'h41;
    endtask

    // advance the bench state by one accepted item, return the letters it yields
    task automatic encrypt_item(input pfe_pkg::cmd_t cmd, input logic [7:0] ch,
                                output int n,
                                output logic [6:0] l1, output logic [6:0] l2);
        logic [7:0] up;
        bit         is_letter;
        logic [4:0] code;
        n = 0;
        l1 = '0;
        l2 = '0;
        up = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'h20 : ch;
        is_letter = (up >= 8'h41 && up <= 8'h5a);
        code = 5'(up - 8'h41);
        if (code == pfe_pkg::CodeJ)
        begin
            code = pfe_pkg::CodeI;
        end
        case (cmd)
            pfe_pkg::CMD_KEY_START:
            begin
                used_map = '0;
                used_map[pfe_pkg::CodeJ] = 1'b1;
                sq_fill = 0;
                sq_done = 1'b0;
                pend_v = 1'b0;
                pend_code = '0;
            end
            pfe_pkg::CMD_KEY_BYTE:
            begin
                if (!sq_done && is_letter)
                begin
                    place_code(code);
                end
            end
            pfe_pkg::CMD_PLAIN:
            begin
                fill_square();
                if (is_letter)
                begin
                    if (!pend_v)
                    begin
                        pend_code = code;
                        pend_v = 1'b1;
                    end
                    else if (pend_code == code)
                    begin
                        cipher_pair(pend_code, pfe_pkg::CodeX, l1, l2);
                        n = 2;
                    end
                    else
                    begin
                        cipher_pair(pend_code, code, l1, l2);
                        pend_v = 1'b0;
                        pend_code = '0;
                        n = 2;
                    end
                end
            end
            default:
            begin
                if (pend_v)
                begin
                    fill_square();
                    cipher_pair(pend_code, pfe_pkg::CodeX, l1, l2);
                    pend_v = 1'b0;
                    pend_code = '0;
                    n = 2;
                end
            end
        endcase
    endtask

    task automatic push_pair(input logic [6:0] l1, input logic [6:0] l2);
        cipher_q.push_back('{letter: l1, pair_end: 1'b0, last: 1'b0});
        cipher_q.push_back('{letter: l2, pair_end: 1'b1, last: 1'b1});
    endtask

    // offer one item, wait for the transfer, then log what it should produce
    task automatic send_item(input pfe_pkg::cmd_t cmd, input logic [7:0] ch,
                             input bit fixed, input int fixed_n,
                             input logic [7:0] e1, input logic [7:0] e2);
        int         n;
        logic [6:0] l1;
        logic [6:0] l2;
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        encrypt_item(cmd, ch, n, l1, l2);
        if (fixed)
        begin
            if (fixed_n == 2)
            begin
                push_pair(e1[6:0], e2[6:0]);
            end
        end
        else if (n == 2)
        begin
            push_pair(l1, l2);
        end
        items_sent++;
        if (cmd == pfe_pkg::CMD_KEY_START)
        begin
            keys_started++;
        end
        @(negedge clk);
    endtask

    task automatic send_checked(input pfe_pkg::cmd_t cmd, input logic [7:0] ch);
        send_item(cmd, ch, 1'b0, 0, 8'h00, 8'h00);
    endtask

    task automatic add_row(input pfe_pkg::cmd_t cmd, input logic [7:0] ch,
                           input bit fixed, input int n,
                           input logic [7:0] e1, input logic [7:0] e2);
        rows.push_back('{cmd: cmd, ch: ch, fixed: fixed, n: n, e1: e1, e2: e2});
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] ch;
        ch = 8'h41 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1) == 1)
        begin
            ch = ch | 8'h20;
        end
        return ch;
    endfunction

    function automatic logic [7:0] rand_plain_byte(input logic [7:0] prev);
        if ($urandom_range(0, 99) < 15)
        begin
            return 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) < 25)
        begin
            return prev;
        end
        return rand_letter();
    endfunction

    task automatic run_message();
        int         key_len;
        int         plain_len;
        logic [7:0] ch;
        ch = 8'h41;
        if ($urandom_range(0, 9) == 0)
        begin
            // noise burst
            repeat ($urandom_range(1, 8))
            begin
                send_checked(pfe_pkg::cmd_t'($urandom_range(0, 3)),
                             8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            send_checked(pfe_pkg::CMD_KEY_START, 8'($urandom_range(0, 255)));
            key_len = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 10);
            repeat (key_len)
            begin
                send_checked(pfe_pkg::CMD_KEY_BYTE, ($urandom_range(0, 9) == 0) ?
                             8'($urandom_range(0, 255)) : rand_letter());
            end
            plain_len = $urandom_range(1, 30);
            repeat (plain_len)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_checked(pfe_pkg::CMD_KEY_BYTE, rand_letter());
                end
                ch = rand_plain_byte(ch);
                send_checked(pfe_pkg::CMD_PLAIN, ch);
            end
            if ($urandom_range(0, 99) < 70)
            begin
                send_checked(pfe_pkg::CMD_END, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // sink side: random stalls plus one long hold on request
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= snk_stall);
        end
    end

    always @(posedge clk)
    begin
        cipher_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cipher_q.size() == 0)
            begin
                if (errors < 10)
                begin
                    $display("unexpected output: data %h pair_end %b last %b",
                             m_tdata, m_tuser, m_tlast);
                end
                errors++;
            end
            else
            begin
                exp = cipher_q.pop_front();
                letters_checked++;
                if (m_tdata !== {1'b0, exp.letter} || m_tuser !== exp.pair_end ||
                    m_tlast !== exp.last)
                begin
                    if (errors < 10)
                    begin
                        $display("output %0d: expected %c/%b/%b, got %h/%b/%b",
                                 letters_checked, {1'b0, exp.letter}, exp.pair_end,
                                 exp.last, m_tdata, m_tuser, m_tlast);
                    end
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int phase;
        int waited;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        src_idle  = 0;
        snk_stall = 0;
        hold_req  = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        errors = 0;
        items_sent = 0;
        letters_checked = 0;
        keys_started = 0;
        used_map = '0;
        used_map[pfe_pkg::CodeJ] = 1'b1;
        sq_fill = 0;
        sq_done = 1'b0;
        pend_v = 1'b0;
        pend_code = '0;
        for (int k = 0; k < SqSize; k++)
        begin
            sq[k] = '0;
        end

        // default square after reset: abcde / fghik / lmnop / qrstu / vwxyz
        add_row(pfe_pkg::CMD_PLAIN,     "A",   1, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_PLAIN,     "B",   1, 2, "B",   "C");
        add_row(pfe_pkg::CMD_PLAIN,     "a",   1, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_PLAIN,     "a",   1, 2, "C",   "V");
        add_row(pfe_pkg::CMD_PLAIN,     "f",   1, 2, "F",   "L");
        add_row(pfe_pkg::CMD_PLAIN,     "j",   1, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_PLAIN,     8'h00, 1, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_PLAIN,     8'hff, 1, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_PLAIN,     "Z",   1, 2, "K",   "Y");
        add_row(pfe_pkg::CMD_END,       "X",   1, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_PLAIN,     "x",   1, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_PLAIN,     "X",   1, 2, "Y",   "Y");
        add_row(pfe_pkg::CMD_END,       8'h80, 1, 2, "Y",   "Y");
        add_row(pfe_pkg::CMD_KEY_START, "Q",   1, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_KEY_BYTE,  "P",   0, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_KEY_BYTE,  "l",   0, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_KEY_BYTE,  "j",   0, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_KEY_BYTE,  "!",   0, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_KEY_BYTE,  "P",   0, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_PLAIN,     ".",   0, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_KEY_BYTE,  "Z",   0, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_PLAIN,     "H",   0, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_PLAIN,     "I",   0, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_PLAIN,     "M",   0, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_KEY_START, 8'h00, 1, 0, 8'h00, 8'h00);
        add_row(pfe_pkg::CMD_END,       "A",   1, 0, 8'h00, 8'h00);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            send_item(rows[i].cmd, rows[i].ch, rows[i].fixed, rows[i].n,
                      rows[i].e1, rows[i].e2);
        end

        hold_req = 1'b1;
        while (items_sent < TargetItems)
        begin
            phase = items_sent * 4 / TargetItems;
            case (phase)
                0:
                begin
                    src_idle  = 0;
                    snk_stall = 0;
                end
                1:
                begin
                    src_idle  = 81;
                    snk_stall = 0;
                end
                2:
                begin
                    src_idle  = 0;
                    snk_stall = 81;
                end
                default:
                begin
                    src_idle  = 11;
                    snk_stall = 11;
                end
            endcase
            run_message();
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (cipher_q.size() != 0 && waited < 100_000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);

        $display("run: %0d items sent over %0d keys, %0d cipher letters checked",
                 items_sent, keys_started, letters_checked);
        $display("sink held for %0d cycles once, idle and stall phases all run",
                 HoldCycles);
        if (errors == 0 && cipher_q.size() == 0)
        begin
            $display("playfair_digraph_encryptor: match");
        end
        else
        begin
            $display("%0d mismatches, %0d letters never arrived", errors, cipher_q.size());
            $display("playfair_digraph_encryptor: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/pfe_pkg.sv
rtl/pfe_ram.sv
rtl/pfe_ctrl.sv
rtl/pfe_datapath.sv
rtl/playfair_digraph_encryptor.sv
tb/playfair_digraph_encryptor_tb.sv
